>>> rtl/sgd_pkg.sv
package sgd_pkg;

    localparam logic [2:0] GESTURE_NONE  = 3'd0;
    localparam logic [2:0] GESTURE_RIGHT = 3'd1;
    localparam logic [2:0] GESTURE_LEFT  = 3'd2;
    localparam logic [2:0] GESTURE_DOWN  = 3'd3;
    localparam logic [2:0] GESTURE_UP    = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [1:0] REG_H_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_V_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_COOLDOWN    = 2'd2;

    localparam logic [30:0] H_THRESHOLD_RESET = 31'd100;
    localparam logic [30:0] V_THRESHOLD_RESET = 31'd100;
    localparam logic [29:0] COOLDOWN_RESET    = 30'd300;

    typedef struct packed {
        logic [1:0]         axis_kind;
        logic signed [15:0] motion_delta;
        logic [31:0]        time_now;
    } sgd_in_t;

    typedef struct packed {
        logic [2:0] gesture_code;
        logic       consumed;
    } sgd_out_t;

endpackage

>>> rtl/swipe_gesture_detector.sv
// Swipe detector for relative pointer motion. X and Y motion beats are absorbed into
// saturating 32-bit per-axis sums; once a sum strictly exceeds its threshold outside the
// cooldown window after the last swipe, a direction is reported (right, left, down, up in
// that order of priority) and both sums clear. An elapsed time above twice the cooldown
// clears the sums before the new delta is added. Other events pass with code 0 and
// consumed 0. One beat is taken every clock unless the output stalls; each result passes
// from its input beat through the input register, then one pass of add/compare logic into the
// result register, and the state update sits in that same single pass, so successive
// beats carry no extra wait. Register writes take effect on the next clock.
module swipe_gesture_detector
    import sgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  sgd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output sgd_out_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    logic [30:0] h_thr_reg;
    logic [30:0] v_thr_reg;
    logic [29:0] cooldown_reg;

    logic        in_valid_reg;
    sgd_in_t     in_data_reg;
    logic        out_valid_reg;
    sgd_out_t    out_data_reg;

    logic signed [31:0] sum_h_reg;
    logic signed [31:0] sum_v_reg;
    logic [31:0]        last_fire_reg;

    logic               advance;
    logic               work;
    logic               is_motion;
    logic               is_x;
    logic [31:0]        elapsed;
    logic               clear_sums;
    logic               cool_done;
    logic signed [31:0] base_h;
    logic signed [31:0] base_v;
    logic signed [31:0] add_in;
    logic signed [32:0] wide_sum;
    logic signed [31:0] sat_sum;
    logic signed [31:0] sum_h_next;
    logic signed [31:0] sum_v_next;
    logic signed [32:0] wide_h;
    logic signed [32:0] wide_v;
    logic signed [32:0] h_lim;
    logic signed [32:0] v_lim;
    logic [2:0]         code;
    sgd_out_t           result;

    assign advance  = !out_valid_reg || !out_stall;
    assign work     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        is_x      = (in_data_reg.axis_kind == AXIS_X);
        is_motion = is_x || (in_data_reg.axis_kind == AXIS_Y);
        elapsed   = in_data_reg.time_now - last_fire_reg;
        // doubled cooldown fits in 31 bits
        clear_sums = elapsed > {1'b0, cooldown_reg, 1'b0};
        cool_done  = elapsed >= {2'b00, cooldown_reg};

        base_h = clear_sums ? 32'sd0 : sum_h_reg;
        base_v = clear_sums ? 32'sd0 : sum_v_reg;
        add_in = is_x ? base_h : base_v;

        wide_sum = {add_in[31], add_in}
                 + {{17{in_data_reg.motion_delta[15]}}, in_data_reg.motion_delta};
        if (wide_sum[32] != wide_sum[31])
        begin
            sat_sum = wide_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        else
        begin
            sat_sum = wide_sum[31:0];
        end

        sum_h_next = is_x ? sat_sum : base_h;
        sum_v_next = is_x ? base_v : sat_sum;

        wide_h = {sum_h_next[31], sum_h_next};
        wide_v = {sum_v_next[31], sum_v_next};
        h_lim  = {2'b00, h_thr_reg};
        v_lim  = {2'b00, v_thr_reg};

        code = GESTURE_NONE;
        if (cool_done)
        begin
            if (wide_h > h_lim)
            begin
                code = GESTURE_RIGHT;
            end
            else if (wide_h < -h_lim)
            begin
                code = GESTURE_LEFT;
            end
            else if (wide_v > v_lim)
            begin
                code = GESTURE_DOWN;
            end
            else if (wide_v < -v_lim)
            begin
                code = GESTURE_UP;
            end
        end

        result.gesture_code = is_motion ? code : GESTURE_NONE;
        result.consumed     = is_motion;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_thr_reg    <= H_THRESHOLD_RESET;
            v_thr_reg    <= V_THRESHOLD_RESET;
            cooldown_reg <= COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_H_THRESHOLD: h_thr_reg    <= cfg_data;
                REG_V_THRESHOLD: v_thr_reg    <= cfg_data;
                REG_COOLDOWN:    cooldown_reg <= cfg_data[29:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_h_reg     <= 32'sd0;
            sum_v_reg     <= 32'sd0;
            last_fire_reg <= 32'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (work && is_motion)
            begin
                if (code != GESTURE_NONE)
                begin
                    sum_h_reg     <= 32'sd0;
                    sum_v_reg     <= 32'sd0;
                    last_fire_reg <= in_data_reg.time_now;
                end
                else
                begin
                    sum_h_reg <= sum_h_next;
                    sum_v_reg <= sum_v_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (work)
        begin
            out_data_reg <= result;
        end
    end

endmodule
